>>> hw/rtl/ffha_pkg.sv
package ffha_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 20;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE     = 5'd0;
  localparam op_t OP_LOAD     = 5'd1;
  localparam op_t OP_SRD      = 5'd2;
  localparam op_t OP_SCHK     = 5'd3;
  localparam op_t OP_ASPLIT   = 5'd4;
  localparam op_t OP_AWHOLE   = 5'd5;
  localparam op_t OP_INS_RD   = 5'd6;
  localparam op_t OP_INS_WR   = 5'd7;
  localparam op_t OP_INS_PUT  = 5'd8;
  localparam op_t OP_FULL     = 5'd9;
  localparam op_t OP_END      = 5'd10;
  localparam op_t OP_OOM      = 5'd11;
  localparam op_t OP_APPEND   = 5'd12;
  localparam op_t OP_BADF     = 5'd13;
  localparam op_t OP_RD_NEXT  = 5'd14;
  localparam op_t OP_MRG_NEXT = 5'd15;
  localparam op_t OP_DRP_RD   = 5'd16;
  localparam op_t OP_DRP_WR   = 5'd17;
  localparam op_t OP_DRP_END  = 5'd18;
  localparam op_t OP_RD_PREV  = 5'd19;
  localparam op_t OP_MRG_PREV = 5'd20;
  localparam op_t OP_PUT_CUR  = 5'd21;
  localparam op_t OP_TR_RD    = 5'd22;
  localparam op_t OP_TR_POP   = 5'd23;
  localparam op_t OP_OUT      = 5'd24;

  typedef struct packed {
    logic        free;
    logic [31:0] size;
    logic [31:0] start;
  } ent_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic null_free;
    logic scan_end;
    logic hit;
    logic split_ok;
    logic full;
    logic oom;
    logic has_next;
    logic has_prev;
    logic rd_free;
    logic ins_done;
    logic drp_more;
    logic cnt_zero;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/ffha_dp.sv
module ffha_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [63:0]                       in_tdata,
  input  logic                              in_tuser,
  input  logic                              cfg_valid,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [63:0]                       out_tdata,
  output logic [1:0]                        out_tuser,
  input  ffha_pkg::cmd_t                    cmd,
  output ffha_pkg::sts_t                    sts
);

  localparam int CW = ffha_pkg::CNT_W;
  localparam int IW = ffha_pkg::IDX_W;
  localparam logic [31:0] HDR = 32'(ffha_pkg::HEADER_BYTES);

  ffha_pkg::ent_t mem_r [ffha_pkg::MAX_BLOCKS];
  ffha_pkg::ent_t rd_r;

  logic          kind_r;
  logic [32:0]   need_r;
  logic [31:0]   fa_r;
  logic [CW-1:0] idx_r, k_r, cnt_r;
  logic [31:0]   brk_r, base_r, limit_r;
  logic [31:0]   cur_start_r, cur_size_r, excess_r;
  logic [33:0]   end_r;
  logic [31:0]   res_addr_r;
  logic [1:0]    res_st_r;
  logic          out_valid_r;
  logic [31:0]   out_addr_r, out_brk_r;
  logic [1:0]    out_st_r;

  logic [CW-1:0] idx_p1, idx_m1, k_p1, k_m1, cnt_m1;
  logic [CW-1:0] ra, wa;
  logic          re, we;
  ffha_pkg::ent_t wd;
  logic          hit;

  assign idx_p1 = idx_r + CW'(1);
  assign idx_m1 = idx_r - CW'(1);
  assign k_p1   = k_r + CW'(1);
  assign k_m1   = k_r - CW'(1);
  assign cnt_m1 = cnt_r - CW'(1);

  assign hit = kind_r ? (!rd_r.free && ({1'b0, rd_r.start} + {1'b0, HDR}) == {1'b0, fa_r})
                      : (rd_r.free && {1'b0, rd_r.size} >= need_r);

  assign sts.kind      = kind_r;
  assign sts.null_free = (fa_r == 32'd0);
  assign sts.scan_end  = (idx_r >= cnt_r);
  assign sts.hit       = hit;
  assign sts.split_ok  = (excess_r > HDR) && (cnt_r < CW'(ffha_pkg::MAX_BLOCKS));
  assign sts.full      = (cnt_r >= CW'(ffha_pkg::MAX_BLOCKS));
  assign sts.oom       = (end_r[33:32] != 2'd0) || (end_r < {2'b00, base_r}) ||
                         ((end_r - {2'b00, base_r}) > {2'b00, limit_r});
  assign sts.has_next  = (idx_p1 < cnt_r);
  assign sts.has_prev  = (idx_r != '0);
  assign sts.rd_free   = rd_r.free;
  assign sts.ins_done  = (k_r == idx_p1);
  assign sts.drp_more  = (k_p1 < cnt_r);
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.out_free  = !out_valid_r || out_tready;

  always_comb begin
    re = 1'b0;
    ra = idx_r;
    we = 1'b0;
    wa = idx_r;
    wd = rd_r;
    unique case (cmd.op)
      ffha_pkg::OP_SRD:     begin re = 1'b1; ra = idx_r;  end
      ffha_pkg::OP_INS_RD:  begin re = 1'b1; ra = k_m1;   end
      ffha_pkg::OP_RD_NEXT: begin re = 1'b1; ra = idx_p1; end
      ffha_pkg::OP_DRP_RD:  begin re = 1'b1; ra = k_p1;   end
      ffha_pkg::OP_RD_PREV: begin re = 1'b1; ra = idx_m1; end
      ffha_pkg::OP_TR_RD:   begin re = 1'b1; ra = cnt_m1; end
      ffha_pkg::OP_ASPLIT: begin
        we = 1'b1; wa = idx_r; wd = '{free: 1'b0, size: need_r[31:0], start: cur_start_r};
      end
      ffha_pkg::OP_AWHOLE: begin
        we = 1'b1; wa = idx_r; wd = '{free: 1'b0, size: cur_size_r, start: cur_start_r};
      end
      ffha_pkg::OP_INS_WR: begin we = 1'b1; wa = k_r; wd = rd_r; end
      ffha_pkg::OP_INS_PUT: begin
        we = 1'b1; wa = idx_p1;
        wd = '{free: 1'b1, size: excess_r, start: cur_start_r + need_r[31:0]};
      end
      ffha_pkg::OP_APPEND: begin
        we = 1'b1; wa = cnt_r; wd = '{free: 1'b0, size: need_r[31:0], start: brk_r};
      end
      ffha_pkg::OP_DRP_WR: begin we = 1'b1; wa = k_r; wd = rd_r; end
      ffha_pkg::OP_MRG_PREV: begin
        we = 1'b1; wa = idx_m1;
        wd = '{free: 1'b1, size: rd_r.size + cur_size_r, start: rd_r.start};
      end
      ffha_pkg::OP_PUT_CUR: begin
        we = 1'b1; wa = idx_r; wd = '{free: 1'b1, size: cur_size_r, start: cur_start_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa[IW-1:0]] <= wd;
    end
    if (re) begin
      rd_r <= mem_r[ra[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      brk_r       <= 32'd0;
      base_r      <= 32'd0;
      limit_r     <= 32'd1048576;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && (cmd.op != ffha_pkg::OP_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        ffha_pkg::OP_LOAD: begin
          kind_r     <= in_tuser;
          need_r     <= {1'b0, HDR} + {1'b0, in_tdata[31:0]};
          fa_r       <= in_tdata[63:32];
          idx_r      <= '0;
          res_addr_r <= 32'd0;
          res_st_r   <= ffha_pkg::ST_OK;
        end
        ffha_pkg::OP_SCHK: begin
          if (hit) begin
            cur_start_r <= rd_r.start;
            cur_size_r  <= rd_r.size;
            excess_r    <= rd_r.size - need_r[31:0];
          end else begin
            idx_r <= idx_p1;
          end
        end
        ffha_pkg::OP_ASPLIT: begin
          k_r        <= cnt_r;
          res_addr_r <= cur_start_r + HDR;
        end
        ffha_pkg::OP_AWHOLE: res_addr_r <= cur_start_r + HDR;
        ffha_pkg::OP_INS_WR:  k_r <= k_m1;
        ffha_pkg::OP_INS_PUT: cnt_r <= cnt_r + CW'(1);
        ffha_pkg::OP_FULL:    res_st_r <= ffha_pkg::ST_FULL;
        ffha_pkg::OP_END:     end_r <= {2'b00, brk_r} + {1'b0, need_r};
        ffha_pkg::OP_OOM:     res_st_r <= ffha_pkg::ST_OOM;
        ffha_pkg::OP_APPEND: begin
          cnt_r      <= cnt_r + CW'(1);
          res_addr_r <= brk_r + HDR;
          brk_r      <= end_r[31:0];
        end
        ffha_pkg::OP_BADF: res_st_r <= ffha_pkg::ST_BADFREE;
        ffha_pkg::OP_MRG_NEXT: begin
          cur_size_r <= cur_size_r + rd_r.size;
          k_r        <= idx_p1;
        end
        ffha_pkg::OP_DRP_WR:   k_r <= k_p1;
        ffha_pkg::OP_DRP_END:  cnt_r <= cnt_m1;
        ffha_pkg::OP_MRG_PREV: k_r <= idx_r;
        ffha_pkg::OP_TR_POP: begin
          brk_r <= brk_r - rd_r.size;
          cnt_r <= cnt_m1;
        end
        ffha_pkg::OP_OUT: begin
          out_valid_r <= 1'b1;
          out_addr_r  <= (res_st_r == ffha_pkg::ST_OK) ? res_addr_r : 32'd0;
          out_st_r    <= res_st_r;
          out_brk_r   <= brk_r;
        end
        default: ;
      endcase
      if (cfg_valid) begin
        unique case (cfg_index)
          ffha_pkg::CFG_HEAP_BASE: begin
            base_r <= cfg_data;
            if (cnt_r == '0) begin
              brk_r <= cfg_data;
            end
          end
          ffha_pkg::CFG_HEAP_LIMIT: limit_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_brk_r, out_addr_r};
  assign out_tuser  = out_st_r;

endmodule

>>> hw/rtl/ffha_ctrl.sv
module ffha_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  ffha_pkg::sts_t sts,
  output ffha_pkg::cmd_t cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_SRD    = 5'd2;
  localparam logic [4:0] S_SCHK   = 5'd3;
  localparam logic [4:0] S_AHIT   = 5'd4;
  localparam logic [4:0] S_INS_RD = 5'd5;
  localparam logic [4:0] S_INS_WR = 5'd6;
  localparam logic [4:0] S_NOFIT  = 5'd7;
  localparam logic [4:0] S_APP    = 5'd8;
  localparam logic [4:0] S_FN_RD  = 5'd9;
  localparam logic [4:0] S_FN_CHK = 5'd10;
  localparam logic [4:0] S_DRP_RD = 5'd11;
  localparam logic [4:0] S_DRP_WR = 5'd12;
  localparam logic [4:0] S_FP_RD  = 5'd13;
  localparam logic [4:0] S_FP_CHK = 5'd14;
  localparam logic [4:0] S_TR_RD  = 5'd15;
  localparam logic [4:0] S_TR_CHK = 5'd16;
  localparam logic [4:0] S_FIN    = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic       ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd.op    = ffha_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op = ffha_pkg::OP_LOAD; state_nxt = S_DISP;
        end
      end
      S_DISP: state_nxt = (sts.kind && sts.null_free) ? S_FIN : S_SRD;
      S_SRD: begin
        if (sts.scan_end) begin
          if (sts.kind) begin
            cmd.op = ffha_pkg::OP_BADF; state_nxt = S_FIN;
          end else begin
            state_nxt = S_NOFIT;
          end
        end else begin
          cmd.op = ffha_pkg::OP_SRD; state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        cmd.op = ffha_pkg::OP_SCHK;
        if (sts.hit) state_nxt = sts.kind ? S_FN_RD : S_AHIT;
        else state_nxt = S_SRD;
      end
      S_AHIT: begin
        if (sts.split_ok) begin
          cmd.op = ffha_pkg::OP_ASPLIT; state_nxt = S_INS_RD;
        end else begin
          cmd.op = ffha_pkg::OP_AWHOLE; state_nxt = S_FIN;
        end
      end
      S_INS_RD: begin
        if (sts.ins_done) begin
          cmd.op = ffha_pkg::OP_INS_PUT; state_nxt = S_FIN;
        end else begin
          cmd.op = ffha_pkg::OP_INS_RD; state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.op = ffha_pkg::OP_INS_WR; state_nxt = S_INS_RD;
      end
      S_NOFIT: begin
        if (sts.full) begin
          cmd.op = ffha_pkg::OP_FULL; state_nxt = S_FIN;
        end else begin
          cmd.op = ffha_pkg::OP_END; state_nxt = S_APP;
        end
      end
      S_APP: begin
        cmd.op    = sts.oom ? ffha_pkg::OP_OOM : ffha_pkg::OP_APPEND;
        state_nxt = S_FIN;
      end
      S_FN_RD: begin
        if (sts.has_next) begin
          cmd.op = ffha_pkg::OP_RD_NEXT; state_nxt = S_FN_CHK;
        end else begin
          state_nxt = S_FP_RD;
        end
      end
      S_FN_CHK: begin
        if (sts.rd_free) begin
          cmd.op = ffha_pkg::OP_MRG_NEXT; ret_nxt = 1'b0; state_nxt = S_DRP_RD;
        end else begin
          state_nxt = S_FP_RD;
        end
      end
      S_DRP_RD: begin
        if (sts.drp_more) begin
          cmd.op = ffha_pkg::OP_DRP_RD; state_nxt = S_DRP_WR;
        end else begin
          cmd.op = ffha_pkg::OP_DRP_END; state_nxt = ret_r ? S_TR_RD : S_FP_RD;
        end
      end
      S_DRP_WR: begin
        cmd.op = ffha_pkg::OP_DRP_WR; state_nxt = S_DRP_RD;
      end
      S_FP_RD: begin
        if (sts.has_prev) begin
          cmd.op = ffha_pkg::OP_RD_PREV; state_nxt = S_FP_CHK;
        end else begin
          cmd.op = ffha_pkg::OP_PUT_CUR; state_nxt = S_TR_RD;
        end
      end
      S_FP_CHK: begin
        if (sts.rd_free) begin
          cmd.op = ffha_pkg::OP_MRG_PREV; ret_nxt = 1'b1; state_nxt = S_DRP_RD;
        end else begin
          cmd.op = ffha_pkg::OP_PUT_CUR; state_nxt = S_TR_RD;
        end
      end
      S_TR_RD: begin
        if (sts.cnt_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.op = ffha_pkg::OP_TR_RD; state_nxt = S_TR_CHK;
        end
      end
      S_TR_CHK: begin
        if (sts.rd_free) begin
          cmd.op = ffha_pkg::OP_TR_POP; state_nxt = S_TR_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.op = ffha_pkg::OP_OUT; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/first_fit_heap_allocator_top.sv
// An allocate scans the table entries in order and, when a split inserts a block, moves the
// entries above it up; a free moves entries down when a merge drops one and trims trailing
// free blocks. A null free goes from dispatch straight to the result, and the next word is
// taken once the controller is back in idle. Requests are handled one word at a time;
// the walks over the block table set the pace.
// Reset (rst_n low, synchronous): table empty, break = heap base = 0, heap limit = 1 MiB.
module first_fit_heap_allocator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [63:0]                    in_tdata,  // [31:0] request_bytes, [63:32] free_addr
  input  logic                           in_tuser,  // [0] kind (0 allocate, 1 free)
  // Result channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata, // [31:0] result_addr, [63:32] break_now
  output logic [1:0]                     out_tuser, // [1:0] status
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  ffha_pkg::cmd_t cmd;
  ffha_pkg::sts_t sts;

  // Configuration writes are taken only while the controller is idle and no request is
  // offered, so a write never lands in the middle of a request.
  assign cfg_ready = in_tready && !in_tvalid;

  // The controller sequences the scan, shift, merge and trim walks over the table.
  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the block table memory, break pointer, registers and result word.
  ffha_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  // A request is never taken in two consecutive cycles.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while previous one in flight");

  // A failed request never returns an address.
  a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ffha_pkg::ST_OK) |-> (out_tdata[31:0] == 32'd0))
    else $error("nonzero address on failure");

  // The result register is only loaded when it is free.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ffha_pkg::OP_OUT) |-> sts.out_free)
    else $error("result overwritten before taken");

endmodule

>>> dv/tb_first_fit_heap_allocator_top.sv
module tb_first_fit_heap_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;
  localparam int   IDLE_LIMIT = 20000;

  // One request word as the block sees it.
  typedef struct packed {
    logic        kind;
    logic [31:0] req_bytes;
    logic [31:0] addr;
  } req_t;

  // One answer word: result address, status and the break afterwards.
  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  status;
    logic [31:0] brk;
  } ans_t;

  // The scoreboard keeps a private copy of the heap table and predicts every answer.
  class heap_scoreboard;
    logic [31:0] base, limit, brk;
    logic [31:0] blk_start [ffha_pkg::MAX_BLOCKS];
    logic [31:0] blk_size [ffha_pkg::MAX_BLOCKS];
    bit          blk_free [ffha_pkg::MAX_BLOCKS];
    int          count;
    ans_t        pending_answers [$];
    logic [31:0] live_addrs [$];
    int          errors, checked, n_oom, n_full, n_bad;

    function void clear();
      base = 0; limit = 32'd1048576; brk = 0; count = 0;
      pending_answers.delete(); live_addrs.delete();
    endfunction

    function void write_reg(logic [ffha_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx == ffha_pkg::CFG_HEAP_BASE) begin
        base = val;
        if (count == 0) brk = val;
      end else if (idx == ffha_pkg::CFG_HEAP_LIMIT) begin
        limit = val;
      end
    endfunction

    function void drop(int idx);
      for (int k = idx; k + 1 < count; k++) begin
        blk_start[k] = blk_start[k+1]; blk_size[k] = blk_size[k+1]; blk_free[k] = blk_free[k+1];
      end
      count--;
    endfunction

    function logic [1:0] allocate(logic [31:0] req, output logic [31:0] addr);
      logic [32:0] need;
      logic [33:0] top;
      logic [31:0] excess;
      addr = 0;
      need = 33'(ffha_pkg::HEADER_BYTES) + 33'(req);
      for (int i = 0; i < count; i++) begin
        if (blk_free[i] && 33'(blk_size[i]) >= need) begin
          excess = blk_size[i] - need[31:0];
          blk_free[i] = 0;
          if (excess > ffha_pkg::HEADER_BYTES && count < ffha_pkg::MAX_BLOCKS) begin
            blk_size[i] = need[31:0];
            for (int k = count; k > i + 1; k--) begin
              blk_start[k] = blk_start[k-1]; blk_size[k] = blk_size[k-1];
              blk_free[k] = blk_free[k-1];
            end
            blk_start[i+1] = blk_start[i] + need[31:0];
            blk_size[i+1] = excess;
            blk_free[i+1] = 1;
            count++;
          end
          addr = blk_start[i] + ffha_pkg::HEADER_BYTES;
          return ffha_pkg::ST_OK;
        end
      end
      if (count >= ffha_pkg::MAX_BLOCKS) return ffha_pkg::ST_FULL;
      top = 34'(brk) + 34'(need);
      if (top > 34'hFFFF_FFFF || top < 34'(base) || top - 34'(base) > 34'(limit))
        return ffha_pkg::ST_OOM;
      blk_start[count] = brk; blk_size[count] = need[31:0]; blk_free[count] = 0;
      count++;
      addr = brk + ffha_pkg::HEADER_BYTES;
      brk = top[31:0];
      return ffha_pkg::ST_OK;
    endfunction

    function logic [1:0] release_block(logic [31:0] a);
      int i;
      if (a == 0) return ffha_pkg::ST_OK;
      i = -1;
      for (int k = 0; k < count; k++)
        if (!blk_free[k] && 33'(blk_start[k]) + ffha_pkg::HEADER_BYTES == 33'(a)) begin
          i = k;
          break;
        end
      if (i < 0) return ffha_pkg::ST_BADFREE;
      blk_free[i] = 1;
      if (i + 1 < count && blk_free[i+1]) begin
        blk_size[i] += blk_size[i+1];
        drop(i + 1);
      end
      if (i > 0 && blk_free[i-1]) begin
        blk_size[i-1] += blk_size[i];
        drop(i);
      end
      while (count > 0 && blk_free[count-1]) begin
        brk -= blk_size[count-1];
        count--;
      end
      return ffha_pkg::ST_OK;
    endfunction

    // Notes an accepted request and queues the answer it must produce.
    function void note_request(req_t r);
      ans_t a;
      logic [31:0] ad;
      if (r.kind == KIND_ALLOC) begin
        a.status = allocate(r.req_bytes, ad);
        if (a.status == ffha_pkg::ST_OK) live_addrs.push_back(ad);
      end else begin
        a.status = release_block(r.addr);
        ad = 0;
        foreach (live_addrs[k])
          if (a.status == ffha_pkg::ST_OK && live_addrs[k] == r.addr) begin
            live_addrs.delete(k);
            break;
          end
      end
      if (a.status == ffha_pkg::ST_OOM) n_oom++;
      if (a.status == ffha_pkg::ST_FULL) n_full++;
      if (a.status == ffha_pkg::ST_BADFREE) n_bad++;
      a.addr = (a.status == ffha_pkg::ST_OK) ? ad : 32'd0;
      a.brk = brk;
      pending_answers.push_back(a);
    endfunction

    function void check_answer(ans_t got);
      ans_t exp_a;
      checked++;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer addr=%h status=%0d break=%h",
                 $time, got.addr, got.status, got.brk);
        errors++;
        return;
      end
      exp_a = pending_answers.pop_front();
      if (got.addr !== exp_a.addr) begin
        $display("%0t: result_addr expected %h actual %h", $time, exp_a.addr, got.addr);
        errors++;
      end
      if (got.status !== exp_a.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_a.status, got.status);
        errors++;
      end
      if (got.brk !== exp_a.brk) begin
        $display("%0t: break_now expected %h actual %h", $time, exp_a.brk, got.brk);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 0, rst_n = 0;
  logic                           in_tvalid = 0, in_tready, in_tuser = 0;
  logic [63:0]                    in_tdata = '0;
  logic                           out_tvalid, out_tready = 0;
  logic [63:0]                    out_tdata;
  logic [1:0]                     out_tuser;
  logic                           cfg_valid = 0, cfg_ready;
  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                    cfg_data = '0;

  heap_scoreboard sb;
  int  idle_cycles, burst_left, stall_mode, sent;
  bit  timed_out;

  first_fit_heap_allocator_top uut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls on its own pattern: phases of always ready, random ready and
  // long stalls, switched at random moments.
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Answers are compared at the edge where they are accepted.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_answer({out_tdata[31:0], out_tuser, out_tdata[63:32]});
  end

  // The watchdog counts cycles where no word moves on any channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired with %0d answers outstanding", sb.pending_answers.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [ffha_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
  endtask

  // Sends one request word. Between bursts the sender idles for a random gap.
  task automatic send(logic kind, logic [31:0] bytes_asked, logic [31:0] addr);
    req_t r;
    if (burst_left == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    r = '{kind, bytes_asked, addr};
    in_tvalid <= 1; in_tuser <= kind; in_tdata <= {addr, bytes_asked};
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (4 * ffha_pkg::MAX_BLOCKS + 16) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_live();
    if (sb.live_addrs.size() == 0) return 32'd0;
    return sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)];
  endfunction

  // Mostly small requests, with the occasional large one and wild value.
  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 4096);
      2: return 0;
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [31:0] a;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8:
          send(KIND_ALLOC, pick_size(), $urandom());
        9, 10, 11, 12, 13, 14, 15, 16:
          send(KIND_FREE, $urandom(), pick_live());
        17: send(KIND_FREE, $urandom(), 32'd0);
        18: begin
          // A live address nudged off its header end, or a small nonzero one when none is live.
          a = pick_live();
          send(KIND_FREE, $urandom(), a + $urandom_range(1, 3));
        end
        default: send(KIND_FREE, $urandom(), $urandom());
      endcase
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    stall_mode = 0; burst_left = 0; sent = 0; idle_cycles = 0; timed_out = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: operations, extremes and the corner cases of the allocator.
    send(KIND_FREE, 32'd0, 32'd0);            // null free on an empty heap
    send(KIND_FREE, 32'hFFFF_FFFF, 32'd20);   // free of something never handed out
    send(KIND_ALLOC, 32'd0, 32'hFFFF_FFFF);   // zero-byte request
    send(KIND_ALLOC, 32'd100, 32'd0);
    send(KIND_ALLOC, 32'd10, 32'd0);
    send(KIND_ALLOC, 32'hFFFF_FFFF, 32'd0);   // overflow of header plus size
    send(KIND_FREE, 32'd0, 32'd40);           // middle block, neighbors busy
    send(KIND_ALLOC, 32'd30, 32'd0);          // split of the freed block
    send(KIND_ALLOC, 32'd1, 32'd0);           // split of the free remainder
    send(KIND_FREE, 32'd0, 32'd40);           // free of the address handed out again by the split
    send(KIND_FREE, 32'd0, 32'd20);
    send(KIND_FREE, 32'd0, 32'd41);           // misaligned address
    send(KIND_ALLOC, 32'd1048556, 32'd0);     // past the heap limit
    drain();

    // Empty the heap, then try the extremes of the base and limit registers.
    while (sb.live_addrs.size() != 0) send(KIND_FREE, 32'd0, sb.live_addrs[0]);
    drain();
    write_reg(ffha_pkg::CFG_HEAP_BASE, 32'hFFFF_FF00);
    write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    send(KIND_ALLOC, 32'd100, 32'd0);
    send(KIND_ALLOC, 32'd200, 32'd0);         // would wrap past the top
    drain();
    write_reg(ffha_pkg::CFG_HEAP_BASE, 32'h0000_1000);  // blocks exist, break stays
    write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd0);
    send(KIND_ALLOC, 32'd0, 32'd0);
    while (sb.live_addrs.size() != 0) send(KIND_FREE, 32'd0, sb.live_addrs[0]);
    drain();

    // Fill the table to exercise the full cases.
    write_reg(ffha_pkg::CFG_HEAP_BASE, 32'h0001_0000);
    write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd1048576);
    for (int k = 0; k < ffha_pkg::MAX_BLOCKS + 1; k++) send(KIND_ALLOC, 32'd40, 32'd0);
    // Highest index first, so the lower picks stay in place as entries leave the list.
    for (int k = ffha_pkg::MAX_BLOCKS - 7; k > 0; k -= 8)
      send(KIND_FREE, 32'd0, sb.live_addrs[k]);
    send(KIND_ALLOC, 32'd4, 32'd0);           // fits but cannot split, table still full
    send(KIND_ALLOC, 32'd500, 32'd0);
    drain();
    while (sb.live_addrs.size() != 0) send(KIND_FREE, 32'd0, pick_live());
    drain();

    // Random phases under several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(ffha_pkg::CFG_HEAP_BASE, 32'd0);
          write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd1048576);
        end
        1: begin
          write_reg(ffha_pkg::CFG_HEAP_BASE, $urandom());
          write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd3000);
        end
        2: begin
          write_reg(ffha_pkg::CFG_HEAP_BASE, 32'hFFFF_0000);
          write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(ffha_pkg::CFG_HEAP_BASE, 32'h8000_0000);
          write_reg(ffha_pkg::CFG_HEAP_LIMIT, $urandom());
        end
        4: begin
          write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd0);
          write_reg(ffha_pkg::CFG_HEAP_BASE, 32'h100);
        end
        default: begin
          write_reg(ffha_pkg::CFG_HEAP_BASE, 32'h40);
          write_reg(ffha_pkg::CFG_HEAP_LIMIT, 32'd20000);
        end
      endcase
      random_phase(ph == 4 ? 50 : 280);
      drain();
      while (sb.live_addrs.size() != 0) send(KIND_FREE, 32'd0, pick_live());
      drain();
    end

    $display("sent %0d requests, checked %0d answers", sent, sb.checked);
    $display("out of memory %0d, table full %0d, invalid free %0d",
             sb.n_oom, sb.n_full, sb.n_bad);
    if (sb.errors == 0 && sb.pending_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_dp.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator_top.sv
dv/tb_first_fit_heap_allocator_top.sv
